// ----- hw/rtl/flt_pkg.sv -----
package flt_pkg;

  localparam int USER_SLOTS = 16;
  localparam int SLOT_W = (USER_SLOTS > 1) ? $clog2(USER_SLOTS) : 1;

  localparam int MODE_W = 2;
  localparam int SLOT_FIELD_W = 4;
  localparam int NOW_W = 48;
  localparam int MS_W = 24;
  localparam int LEVEL_W = 4;
  localparam int CFG_IDX_W = 2;

  localparam logic [MODE_W-1:0] MODE_CHECK = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FAILURE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SUCCESS = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_ONE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_TWO = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_THREE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_FOUR = 2'd3;

  localparam logic [MS_W-1:0] RST_LEVEL_ONE_MS = 24'd60000;
  localparam logic [MS_W-1:0] RST_LEVEL_TWO_MS = 24'd300000;
  localparam logic [MS_W-1:0] RST_LEVEL_THREE_MS = 24'd900000;
  localparam logic [MS_W-1:0] RST_LEVEL_FOUR_MS = 24'd1800000;

  localparam logic [LEVEL_W-1:0] LEVEL_FIRST_LOCK = 4'd5;
  localparam logic [LEVEL_W-1:0] LEVEL_SECOND_LOCK = 4'd6;
  localparam logic [LEVEL_W-1:0] LEVEL_THIRD_LOCK = 4'd7;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 4'd8;

  typedef struct packed {
    logic [MODE_W-1:0]       mode;
    logic [SLOT_FIELD_W-1:0] user_slot;
    logic [NOW_W-1:0]        now_ms;
  } in_t;

  typedef struct packed {
    logic [MS_W-1:0] remaining_ms;
    logic            locked;
  } out_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [NOW_W-1:0]   last_ms;
  } entry_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_FINISH
  } state_t;

endpackage

// ----- hw/rtl/failed_attempt_lockout_table.sv -----
// The result strobe is registered: a request is read from the table when it is accepted, then passes CALC and FINISH.
// A new request is taken only once the last is through: busy stays high while the table read, the deadline add
// and the compare-subtract with write-back run in turn for each request.
// Reset: synchronous and active low; afterwards a clearing pass zeroes one table entry
// per cycle, all USER_SLOTS entries, with busy high; configuration writes are taken always.
// The receiver cannot stall: each result is shown for exactly one cycle.
module failed_attempt_lockout_table (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  flt_pkg::in_t                       in_data,
  output logic                               out_valid,
  output flt_pkg::out_t                      out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [flt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [flt_pkg::MS_W-1:0]           cfg_data
);

  flt_pkg::state_t state_r, state_nxt;
  logic [flt_pkg::SLOT_W-1:0] clr_idx_r, clr_idx_nxt;

  logic [flt_pkg::MS_W-1:0] lvl_one_r, lvl_two_r, lvl_three_r, lvl_four_r;

  flt_pkg::in_t   req_r;
  logic           in_range_r;
  flt_pkg::entry_t rd_r;
  logic [flt_pkg::MS_W-1:0]    tmo_r, tmo_nxt;
  logic [flt_pkg::NOW_W:0]     deadline_r, deadline_nxt;
  logic                        back_r, back_nxt;
  flt_pkg::out_t               out_r, out_nxt;
  logic                        out_valid_r, out_valid_nxt;

  flt_pkg::entry_t mem [flt_pkg::USER_SLOTS];
  logic                       mem_we;
  logic [flt_pkg::SLOT_W-1:0] mem_waddr;
  flt_pkg::entry_t            mem_wdata;

  logic                                       accept;
  logic [flt_pkg::SLOT_W+flt_pkg::SLOT_FIELD_W-1:0] slot_ext;
  logic [flt_pkg::SLOT_W-1:0]                 rd_idx;
  logic                                       in_range;
  logic [flt_pkg::SLOT_W+flt_pkg::SLOT_FIELD_W-1:0] req_slot_ext;
  logic [flt_pkg::NOW_W+1:0]                  diff;
  logic [flt_pkg::LEVEL_W-1:0]                lvl_clamped;

  assign busy      = (state_r != flt_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign slot_ext     = {{flt_pkg::SLOT_W{1'b0}}, in_data.user_slot};
  assign rd_idx       = slot_ext[flt_pkg::SLOT_W-1:0];
  assign in_range     = (32'(in_data.user_slot) < flt_pkg::USER_SLOTS);
  assign req_slot_ext = {{flt_pkg::SLOT_W{1'b0}}, req_r.user_slot};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lvl_one_r   <= flt_pkg::RST_LEVEL_ONE_MS;
      lvl_two_r   <= flt_pkg::RST_LEVEL_TWO_MS;
      lvl_three_r <= flt_pkg::RST_LEVEL_THREE_MS;
      lvl_four_r  <= flt_pkg::RST_LEVEL_FOUR_MS;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        flt_pkg::CFG_LEVEL_ONE:   lvl_one_r   <= cfg_data;
        flt_pkg::CFG_LEVEL_TWO:   lvl_two_r   <= cfg_data;
        flt_pkg::CFG_LEVEL_THREE: lvl_three_r <= cfg_data;
        flt_pkg::CFG_LEVEL_FOUR:  lvl_four_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r       <= mem[rd_idx];
      req_r      <= in_data;
      in_range_r <= in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= flt_pkg::ST_CLEAR;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tmo_r      <= tmo_nxt;
    deadline_r <= deadline_nxt;
    back_r     <= back_nxt;
    out_r      <= out_nxt;
  end

  always_comb begin
    lvl_clamped = (rd_r.level > flt_pkg::LEVEL_MAX) ? flt_pkg::LEVEL_MAX : rd_r.level;
    diff = {1'b0, deadline_r} - {2'b00, req_r.now_ms};
  end

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    tmo_nxt       = tmo_r;
    deadline_nxt  = deadline_r;
    back_nxt      = back_r;
    mem_we        = 1'b0;
    mem_waddr     = req_slot_ext[flt_pkg::SLOT_W-1:0];
    mem_wdata     = rd_r;

    unique case (state_r)
      flt_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx_r;
        mem_wdata = '0;
        if (clr_idx_r == flt_pkg::SLOT_W'(flt_pkg::USER_SLOTS - 1)) begin
          state_nxt = flt_pkg::ST_IDLE;
        end else begin
          clr_idx_nxt = clr_idx_r + 1'b1;
        end
      end
      flt_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = flt_pkg::ST_CALC;
        end
      end
      flt_pkg::ST_CALC: begin
        if (lvl_clamped < flt_pkg::LEVEL_FIRST_LOCK) begin
          tmo_nxt = '0;
        end else if (lvl_clamped == flt_pkg::LEVEL_FIRST_LOCK) begin
          tmo_nxt = lvl_one_r;
        end else if (lvl_clamped == flt_pkg::LEVEL_SECOND_LOCK) begin
          tmo_nxt = lvl_two_r;
        end else if (lvl_clamped == flt_pkg::LEVEL_THIRD_LOCK) begin
          tmo_nxt = lvl_three_r;
        end else begin
          tmo_nxt = lvl_four_r;
        end
        deadline_nxt = {1'b0, rd_r.last_ms} + {{(flt_pkg::NOW_W + 1 - flt_pkg::MS_W){1'b0}},
                                               tmo_nxt};
        back_nxt     = (req_r.now_ms <= rd_r.last_ms);
        state_nxt    = flt_pkg::ST_FINISH;
      end
      flt_pkg::ST_FINISH: begin
        out_valid_nxt        = 1'b1;
        out_nxt.remaining_ms = '0;
        if (in_range_r) begin
          case (req_r.mode)
            flt_pkg::MODE_CHECK: begin
              if (tmo_r == '0) begin
                out_nxt.remaining_ms = '0;
              end else if (back_r) begin
                mem_we               = 1'b1;
                mem_wdata.last_ms    = req_r.now_ms;
                out_nxt.remaining_ms = tmo_r;
              end else if (!diff[flt_pkg::NOW_W+1] && (diff != '0)) begin
                out_nxt.remaining_ms = diff[flt_pkg::MS_W-1:0];
              end
            end
            flt_pkg::MODE_FAILURE: begin
              mem_we            = 1'b1;
              mem_wdata.level   = (rd_r.level < flt_pkg::LEVEL_MAX) ?
                                  rd_r.level + 1'b1 : rd_r.level;
              mem_wdata.last_ms = req_r.now_ms;
            end
            flt_pkg::MODE_SUCCESS: begin
              mem_we    = 1'b1;
              mem_wdata = '0;
            end
            default: ;
          endcase
        end
        out_nxt.locked = (out_nxt.remaining_ms != '0);
        state_nxt      = flt_pkg::ST_IDLE;
      end
      default: state_nxt = flt_pkg::ST_IDLE;
    endcase
  end

endmodule

// ----- hw/rtl/flt_checker.sv -----
module flt_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input flt_pkg::in_t                  in_data,
  input logic                          out_valid,
  input flt_pkg::out_t                 out_data,
  input logic                          cfg_valid,
  input logic                          cfg_ready,
  input logic [flt_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [flt_pkg::MS_W-1:0]      cfg_data
);

  // Each accepted request must be followed by a result strobe.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##3 out_valid)
    else $error("accepted request produced no result");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block did not go busy after a request");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe lasted more than one cycle");

  a_locked_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.locked == (out_data.remaining_ms != '0)))
    else $error("locked flag disagrees with remaining time");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result appeared without a request in flight");

endmodule

bind failed_attempt_lockout_table flt_checker u_flt_checker (.*);

// ----- tb/sv/failed_attempt_lockout_table_tb.sv -----
module failed_attempt_lockout_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [flt_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;
  localparam int IN_W = $bits(flt_pkg::in_t);
  localparam int SETTLE_CYCLES = 8;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int MAX_REPORTS = 10;

  logic                          clk;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  flt_pkg::in_t                  in_data;
  logic                          out_valid;
  flt_pkg::out_t                 out_data;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [flt_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [flt_pkg::MS_W-1:0]      cfg_data;

  logic [flt_pkg::LEVEL_W-1:0] slot_level [flt_pkg::USER_SLOTS];
  logic [flt_pkg::NOW_W-1:0]   slot_last_ms [flt_pkg::USER_SLOTS];
  logic [flt_pkg::MS_W-1:0]    lockout_ms [4];

  flt_pkg::out_t pending_verdicts [$];
  int            mismatches;
  int            quiet_cycles;
  int            burst_left;
  bit            steady_stream;

  failed_attempt_lockout_table u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic flt_pkg::out_t predict_attempt(
      input logic [flt_pkg::MODE_W-1:0] mode,
      input logic [flt_pkg::SLOT_FIELD_W-1:0] slot,
      input logic [flt_pkg::NOW_W-1:0] now);
    flt_pkg::out_t               verdict;
    logic [flt_pkg::MS_W-1:0]    tmo;
    logic [flt_pkg::NOW_W:0]     deadline;
    logic [flt_pkg::LEVEL_W-1:0] lvl;
    verdict = '0;
    if (int'(slot) < flt_pkg::USER_SLOTS) begin
      lvl = slot_level[slot];
      case (mode)
        flt_pkg::MODE_CHECK: begin
          case (lvl)
            flt_pkg::LEVEL_FIRST_LOCK:  tmo = lockout_ms[flt_pkg::CFG_LEVEL_ONE];
            flt_pkg::LEVEL_SECOND_LOCK: tmo = lockout_ms[flt_pkg::CFG_LEVEL_TWO];
            flt_pkg::LEVEL_THIRD_LOCK:  tmo = lockout_ms[flt_pkg::CFG_LEVEL_THREE];
            default: begin
              tmo = (lvl >= flt_pkg::LEVEL_MAX) ? lockout_ms[flt_pkg::CFG_LEVEL_FOUR] : '0;
            end
          endcase
          deadline = slot_last_ms[slot] + tmo;
          if (tmo != '0) begin
            if (now > slot_last_ms[slot] && {1'b0, now} < deadline) begin
              verdict.remaining_ms = flt_pkg::MS_W'(deadline - now);
            end else if (now <= slot_last_ms[slot]) begin
              slot_last_ms[slot] = now;
              verdict.remaining_ms = tmo;
            end
          end
        end
        flt_pkg::MODE_FAILURE: begin
          if (lvl < flt_pkg::LEVEL_MAX) slot_level[slot] = lvl + 1'b1;
          slot_last_ms[slot] = now;
        end
        flt_pkg::MODE_SUCCESS: begin
          slot_level[slot] = '0;
          slot_last_ms[slot] = '0;
        end
        default: ;
      endcase
    end
    verdict.locked = (verdict.remaining_ms != '0);
    return verdict;
  endfunction

  task automatic send_attempt(input logic [flt_pkg::MODE_W-1:0] mode,
                              input logic [flt_pkg::SLOT_FIELD_W-1:0] slot,
                              input logic [flt_pkg::NOW_W-1:0] now);
    flt_pkg::in_t req;
    int           gap;
    req.mode = mode;
    req.user_slot = slot;
    req.now_ms = now;
    start <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (busy !== 1'b0);
    pending_verdicts.push_back(predict_attempt(mode, slot, now));
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (steady_stream || $urandom_range(0, 2) == 0) gap = 0;
      else gap = $urandom_range(1, ($urandom_range(0, 7) == 0) ? 24 : 5);
      if (gap > 0) begin
        start <= 1'b0;
        in_data <= flt_pkg::in_t'(IN_W'({$urandom(), $urandom()}));
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_lockouts(input logic [flt_pkg::MS_W-1:0] one,
                                  input logic [flt_pkg::MS_W-1:0] two,
                                  input logic [flt_pkg::MS_W-1:0] three,
                                  input logic [flt_pkg::MS_W-1:0] four);
    logic [flt_pkg::CFG_IDX_W-1:0] idx_list [4];
    logic [flt_pkg::MS_W-1:0]      val_list [4];
    idx_list = '{flt_pkg::CFG_LEVEL_ONE, flt_pkg::CFG_LEVEL_TWO, flt_pkg::CFG_LEVEL_THREE,
                 flt_pkg::CFG_LEVEL_FOUR};
    val_list = '{one, two, three, four};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx_list[flt_pkg::CFG_IDX_W'(i)];
      cfg_data <= val_list[flt_pkg::CFG_IDX_W'(i)];
      do @(posedge clk); while (cfg_ready !== 1'b1);
      lockout_ms[idx_list[flt_pkg::CFG_IDX_W'(i)]] = val_list[flt_pkg::CFG_IDX_W'(i)];
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random_phase(input int count);
    logic [flt_pkg::NOW_W-1:0]        clock_ms;
    logic [flt_pkg::NOW_W-1:0]        now;
    logic [flt_pkg::MODE_W-1:0]       mode;
    logic [flt_pkg::SLOT_FIELD_W-1:0] slot;
    int unsigned                      step_max;
    int                               hot_base;
    int                               roll;
    step_max = 0;
    for (int i = 0; i < 4; i++) begin
      if (lockout_ms[flt_pkg::CFG_IDX_W'(i)] > step_max) begin
        step_max = 32'(lockout_ms[flt_pkg::CFG_IDX_W'(i)]);
      end
    end
    if (step_max == 0) step_max = 1000;
    hot_base = $urandom_range(0, flt_pkg::USER_SLOTS - 3);
    case ($urandom_range(0, 2))
      0: clock_ms = '0;
      1: clock_ms = '1 - flt_pkg::NOW_W'($urandom_range(0, 4 * step_max));
      default: clock_ms = flt_pkg::NOW_W'({$urandom(), $urandom()});
    endcase
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 45) mode = flt_pkg::MODE_CHECK;
      else if (roll < 85) mode = flt_pkg::MODE_FAILURE;
      else if (roll < 92) mode = flt_pkg::MODE_SUCCESS;
      else if (roll < 95) mode = MODE_UNUSED;
      else mode = flt_pkg::MODE_CHECK;
      if ($urandom_range(0, 4) == 0) begin
        slot = flt_pkg::SLOT_FIELD_W'($urandom_range(0, flt_pkg::USER_SLOTS - 1));
      end else begin
        slot = flt_pkg::SLOT_FIELD_W'(hot_base + $urandom_range(0, 2));
      end
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        clock_ms = flt_pkg::NOW_W'({$urandom(), $urandom()});
        now = clock_ms;
      end else if (roll < 10) begin
        now = clock_ms - flt_pkg::NOW_W'($urandom_range(0, step_max));
      end else if (roll < 14) begin
        now = clock_ms;
      end else begin
        if ($urandom_range(0, 3) == 0) clock_ms += flt_pkg::NOW_W'($urandom_range(0, step_max));
        else clock_ms += flt_pkg::NOW_W'($urandom_range(0, step_max >> 4));
        now = clock_ms;
      end
      send_attempt(mode, slot, now);
    end
  endtask

  task automatic test_directed_corners();
    logic [flt_pkg::NOW_W-1:0] top;
    top = '1;
    steady_stream = 1'b0;
    send_attempt(flt_pkg::MODE_CHECK, 4'd0, '0);
    send_attempt(MODE_UNUSED, 4'd15, top);
    repeat (5) send_attempt(flt_pkg::MODE_FAILURE, 4'd15, top - 48'd5);
    // The deadline here lies past the top of the 48-bit time range.
    send_attempt(flt_pkg::MODE_CHECK, 4'd15, top);
    send_attempt(flt_pkg::MODE_CHECK, 4'd15, top - 48'd5);
    send_attempt(flt_pkg::MODE_CHECK, 4'd15, '0);
    send_attempt(flt_pkg::MODE_CHECK, 4'd15,
                 flt_pkg::NOW_W'(lockout_ms[flt_pkg::CFG_LEVEL_ONE]));
    send_attempt(flt_pkg::MODE_CHECK, 4'd15,
                 flt_pkg::NOW_W'(lockout_ms[flt_pkg::CFG_LEVEL_ONE]) - 48'd1);
    repeat (4) send_attempt(flt_pkg::MODE_FAILURE, 4'd15, 48'd100);
    send_attempt(flt_pkg::MODE_CHECK, 4'd15, 48'd101);
    send_attempt(flt_pkg::MODE_SUCCESS, 4'd15, top);
    send_attempt(flt_pkg::MODE_CHECK, 4'd15, 48'd101);
    send_attempt(flt_pkg::MODE_FAILURE, 4'd0, top);
    send_attempt(flt_pkg::MODE_CHECK, 4'd0, top);
    drain_results();
  endtask

  task automatic test_default_timeouts();
    steady_stream = 1'b1;
    run_random_phase(150);
    steady_stream = 1'b0;
    run_random_phase(350);
    drain_results();
  endtask

  task automatic test_saturated_timeouts();
    program_lockouts('1, '1, '1, '1);
    run_random_phase(300);
    drain_results();
  endtask

  task automatic test_zero_timeouts();
    program_lockouts('0, '0, '0, '0);
    run_random_phase(150);
    drain_results();
  endtask

  task automatic test_unit_timeouts();
    program_lockouts(24'd1, 24'd1, 24'd1, 24'd1);
    steady_stream = 1'b1;
    run_random_phase(150);
    steady_stream = 1'b0;
    drain_results();
  endtask

  task automatic test_random_timeouts();
    logic [flt_pkg::MS_W-1:0] vals [4];
    repeat (4) begin
      for (int i = 0; i < 4; i++) begin
        vals[flt_pkg::CFG_IDX_W'(i)] =
          flt_pkg::MS_W'($urandom_range(0, 24'hFFFFFF) >> $urandom_range(0, 16));
      end
      program_lockouts(vals[0], vals[1], vals[2], vals[3]);
      run_random_phase(175);
      drain_results();
    end
  endtask

  function automatic void log_mismatch(input string why, input flt_pkg::out_t want,
                                       input flt_pkg::out_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("mismatch (%s): expected remaining_ms=%0d locked=%0b,", why,
               want.remaining_ms, want.locked,
               " got remaining_ms=%0d locked=%0b", got.remaining_ms, got.locked);
    end
  endfunction

  always @(posedge clk) begin
    flt_pkg::out_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_verdicts.size() == 0) begin
        log_mismatch("no request outstanding", '0, out_data);
      end else begin
        want = pending_verdicts.pop_front();
        if (out_data.remaining_ms !== want.remaining_ms ||
            out_data.locked !== want.locked) begin
          log_mismatch("wrong verdict", want, out_data);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1 ||
        (cfg_valid === 1'b1 && cfg_ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = flt_pkg::CFG_LEVEL_ONE;
    cfg_data = '0;
    mismatches = 0;
    quiet_cycles = 0;
    burst_left = 0;
    steady_stream = 1'b0;
    lockout_ms[flt_pkg::CFG_LEVEL_ONE] = flt_pkg::RST_LEVEL_ONE_MS;
    lockout_ms[flt_pkg::CFG_LEVEL_TWO] = flt_pkg::RST_LEVEL_TWO_MS;
    lockout_ms[flt_pkg::CFG_LEVEL_THREE] = flt_pkg::RST_LEVEL_THREE_MS;
    lockout_ms[flt_pkg::CFG_LEVEL_FOUR] = flt_pkg::RST_LEVEL_FOUR_MS;
    for (int i = 0; i < flt_pkg::USER_SLOTS; i++) begin
      slot_level[flt_pkg::SLOT_W'(i)] = '0;
      slot_last_ms[flt_pkg::SLOT_W'(i)] = '0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_corners();
    test_default_timeouts();
    test_saturated_timeouts();
    test_zero_timeouts();
    test_unit_timeouts();
    test_random_timeouts();
    drain_results();
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
